>>> hw/rtl/bvm_pkg.sv
// ----------------------------------------------------------------------------
// bvm_pkg
// shared widths, constants and types of the battery voltage monitor
// ----------------------------------------------------------------------------
package bvm_pkg;

	localparam int AdcW     = 12;
	localparam int VoltW    = 23;
	localparam int PctW     = 7;
	localparam int StatW    = 2;
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 23;
	localparam int ProdW    = 32;
	localparam int NumW     = 30;
	localparam int DivSteps = NumW;
	localparam int CntW     = $clog2(DivSteps);

	localparam logic [VoltW-1:0] LowRangeLimit   = 23'd2500000;
	localparam logic [19:0]      LowMult         = 20'd78125;
	localparam logic [19:0]      HighMult        = 20'd924375;
	localparam int               LowShift        = 7;
	localparam int               HighShift       = 9;
	localparam logic [VoltW-1:0] HighOffset      = 23'd33000;
	localparam logic [VoltW-1:0] ChangeThreshold = 23'd50000;
	localparam logic [PctW-1:0]  PctFull         = 7'd100;

	localparam logic [VoltW-1:0] VoltMinReset = 23'd3600000;
	localparam logic [VoltW-1:0] VoltMaxReset = 23'd4200000;

	typedef enum logic [StatW-1:0] {
		STAT_UNKNOWN      = 2'd0,
		STAT_CHARGING     = 2'd1,
		STAT_NOT_CHARGING = 2'd2
	} charge_stat_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_VOLTAGE_MIN        = 2'd0,
		REG_VOLTAGE_MAX        = 2'd1,
		REG_CHARGE_PIN_PRESENT = 2'd2,
		REG_CHARGE_ACTIVE_LOW  = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE,
		ST_VOLT,
		ST_PREP,
		ST_NUM,
		ST_DIV,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic load_in;
		logic scale;
		logic volt;
		logic prep;
		logic num;
		logic div_step;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic out_busy;
	} dp_stat_t;

endpackage

>>> hw/rtl/bvm_stream_if.sv
// ----------------------------------------------------------------------------
// bvm_sample_if / bvm_result_if
// valid/ready channels for battery samples and gauge results
// ----------------------------------------------------------------------------
interface bvm_sample_if;
	logic                      valid;
	logic                      ready;
	logic [bvm_pkg::AdcW-1:0]  adc_sample;
	logic                      sample_ok;
	logic                      charge_pin;

	modport source (output valid, output adc_sample, output sample_ok, output charge_pin,
		input ready);
	modport sink (input valid, input adc_sample, input sample_ok, input charge_pin,
		output ready);
endinterface

interface bvm_result_if;
	logic                      valid;
	logic                      ready;
	logic [bvm_pkg::VoltW-1:0] voltage_uv;
	logic [bvm_pkg::PctW-1:0]  capacity_pct;
	logic                      health_dead;
	logic [bvm_pkg::StatW-1:0] charge_status;
	logic                      read_error;
	logic                      changed;

	modport source (output valid, output voltage_uv, output capacity_pct, output health_dead,
		output charge_status, output read_error, output changed, input ready);
	modport sink (input valid, input voltage_uv, input capacity_pct, input health_dead,
		input charge_status, input read_error, input changed, output ready);
endinterface

>>> hw/rtl/battery_voltage_monitor_core.sv
// ----------------------------------------------------------------------------
// battery_voltage_monitor_core
// linear battery gauge: adc scaling, capacity, health, charge status, change
// ----------------------------------------------------------------------------
// channel     dir   handshake      payload
// sample_ch   in    valid/ready    adc_sample, sample_ok, charge_pin
// result_ch   out   valid/ready    voltage_uv, capacity_pct, health_dead,
//                                  charge_status, read_error, changed
// cfg         in    cfg_we         cfg_index, cfg_data
//
// one transaction at a time: capture, the scale, volt, prep and num setup steps, a 30-step
// restoring divider for the capacity percentage, then the result write
// the next sample is taken while a finished result waits in the output register
// a result stalled downstream holds the sequencer only at the result write
// arst_n clears the sequencer, config to defaults and the tracked state
// ----------------------------------------------------------------------------
module battery_voltage_monitor_core (
	input  logic                          clk,
	input  logic                          arst_n,
	bvm_sample_if.sink                    sample_ch,
	bvm_result_if.source                  result_ch,
	input  logic                          cfg_we,
	input  logic [bvm_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [bvm_pkg::CfgDataW-1:0]  cfg_data
);

	bvm_pkg::dp_cmd_t  cmd;
	bvm_pkg::dp_stat_t stat;

	bvm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_ch.valid),
		.sample_ready (sample_ch.ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	bvm_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.adc_sample    (sample_ch.adc_sample),
		.sample_ok     (sample_ch.sample_ok),
		.charge_pin    (sample_ch.charge_pin),
		.out_valid     (result_ch.valid),
		.out_ready     (result_ch.ready),
		.voltage_uv    (result_ch.voltage_uv),
		.capacity_pct  (result_ch.capacity_pct),
		.health_dead   (result_ch.health_dead),
		.charge_status (result_ch.charge_status),
		.read_error    (result_ch.read_error),
		.changed       (result_ch.changed)
	);

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		sample_ch.valid && sample_ch.ready |-> cmd.load_in)
		else $error("sample transaction without capture");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(result_ch.valid && !result_ch.ready))
		else $error("result overwritten while stalled");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> result_ch.valid)
		else $error("loaded result not presented");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> !sample_ch.ready)
		else $error("sample accepted during division");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid |-> result_ch.capacity_pct <= bvm_pkg::PctFull)
		else $error("capacity above full scale");

endmodule

>>> hw/rtl/bvm_ctrl.sv
// ----------------------------------------------------------------------------
// bvm_ctrl
// sequencer: sample capture, scaling, capacity division and result hand-off
// ----------------------------------------------------------------------------
module bvm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_ready,
	input  bvm_pkg::dp_stat_t  stat,
	output bvm_pkg::dp_cmd_t   cmd
);

	bvm_pkg::state_t              state_q, state_d;
	logic [bvm_pkg::CntW-1:0]     cnt_q;
	logic                         div_last;

	assign div_last = (cnt_q == bvm_pkg::CntW'(bvm_pkg::DivSteps - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bvm_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == bvm_pkg::ST_NUM) begin
				cnt_q <= '0;
			end else if (state_q == bvm_pkg::ST_DIV) begin
				cnt_q <= cnt_q + bvm_pkg::CntW'(1);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			bvm_pkg::ST_IDLE: begin
				if (sample_valid) state_d = bvm_pkg::ST_SCALE;
			end
			bvm_pkg::ST_SCALE: state_d = bvm_pkg::ST_VOLT;
			bvm_pkg::ST_VOLT:  state_d = bvm_pkg::ST_PREP;
			bvm_pkg::ST_PREP:  state_d = bvm_pkg::ST_NUM;
			bvm_pkg::ST_NUM:   state_d = bvm_pkg::ST_DIV;
			bvm_pkg::ST_DIV: begin
				if (div_last) state_d = bvm_pkg::ST_WRITE;
			end
			bvm_pkg::ST_WRITE: begin
				if (!stat.out_busy) state_d = bvm_pkg::ST_IDLE;
			end
			default: state_d = bvm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		sample_ready = 1'b0;
		case (state_q)
			bvm_pkg::ST_IDLE: begin
				sample_ready = 1'b1;
				cmd.load_in  = sample_valid;
			end
			bvm_pkg::ST_SCALE: cmd.scale    = 1'b1;
			bvm_pkg::ST_VOLT:  cmd.volt     = 1'b1;
			bvm_pkg::ST_PREP:  cmd.prep     = 1'b1;
			bvm_pkg::ST_NUM:   cmd.num      = 1'b1;
			bvm_pkg::ST_DIV:   cmd.div_step = 1'b1;
			bvm_pkg::ST_WRITE: cmd.load_out = !stat.out_busy;
			default: cmd = '0;
		endcase
	end

endmodule

>>> hw/rtl/bvm_datapath.sv
// ----------------------------------------------------------------------------
// bvm_datapath
// config registers, voltage scaling, status tracking, serial divider, result
// ----------------------------------------------------------------------------
module bvm_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bvm_pkg::dp_cmd_t              cmd,
	output bvm_pkg::dp_stat_t             stat,
	input  logic                          cfg_we,
	input  logic [bvm_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [bvm_pkg::CfgDataW-1:0]  cfg_data,
	input  logic [bvm_pkg::AdcW-1:0]      adc_sample,
	input  logic                          sample_ok,
	input  logic                          charge_pin,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bvm_pkg::VoltW-1:0]     voltage_uv,
	output logic [bvm_pkg::PctW-1:0]      capacity_pct,
	output logic                          health_dead,
	output logic [bvm_pkg::StatW-1:0]     charge_status,
	output logic                          read_error,
	output logic                          changed
);

	localparam int VoltW = bvm_pkg::VoltW;
	localparam int NumW  = bvm_pkg::NumW;
	localparam int ProdW = bvm_pkg::ProdW;

	// configuration
	logic [VoltW-1:0]      vmin_q, vmax_q;
	logic                  pin_present_q, active_low_q;

	// item registers
	logic [bvm_pkg::AdcW-1:0] adc_q;
	logic                     ok_q, pin_q;
	logic [ProdW-1:0]         prod_q;
	logic [VoltW-1:0]         v_q, vdiff_q, den_q, rem_q;
	logic                     cap_zero_q, dead_q, chg_q;
	logic [NumW-1:0]          num_q;

	// tracked state
	logic [VoltW-1:0]         rep_volt_q;
	bvm_pkg::charge_stat_t    rep_stat_q;

	// output register
	logic                     out_valid_q;

	logic                     low_range;
	logic [19:0]              mult;
	logic [VoltW-1:0]         v_scaled, absdiff;
	logic                     volt_move, stat_move;
	bvm_pkg::charge_stat_t    pin_stat;
	logic [VoltW:0]           rem_next;
	logic                     rem_ge;
	logic [bvm_pkg::PctW-1:0] cap_val;

	assign low_range = (vmax_q <= bvm_pkg::LowRangeLimit);
	assign mult      = low_range ? bvm_pkg::LowMult : bvm_pkg::HighMult;
	assign v_scaled  = low_range ? VoltW'(prod_q >> bvm_pkg::LowShift)
		: VoltW'(prod_q >> bvm_pkg::HighShift) + bvm_pkg::HighOffset;

	assign absdiff   = (v_q >= rep_volt_q) ? (v_q - rep_volt_q) : (rep_volt_q - v_q);
	assign volt_move = ok_q && (absdiff > bvm_pkg::ChangeThreshold);
	assign pin_stat  = (pin_q ^ active_low_q) ? bvm_pkg::STAT_CHARGING
		: bvm_pkg::STAT_NOT_CHARGING;
	assign stat_move = pin_present_q && (pin_stat != rep_stat_q);

	assign rem_next  = {rem_q, num_q[NumW-1]};
	assign rem_ge    = (rem_next >= {1'b0, den_q});

	assign cap_val   = (num_q > NumW'(bvm_pkg::PctFull)) ? bvm_pkg::PctFull
		: num_q[bvm_pkg::PctW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vmin_q        <= bvm_pkg::VoltMinReset;
			vmax_q        <= bvm_pkg::VoltMaxReset;
			pin_present_q <= 1'b0;
			active_low_q  <= 1'b0;
			rep_volt_q    <= '0;
			rep_stat_q    <= bvm_pkg::STAT_UNKNOWN;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (bvm_pkg::cfg_reg_t'(cfg_index))
					bvm_pkg::REG_VOLTAGE_MIN:        vmin_q        <= cfg_data;
					bvm_pkg::REG_VOLTAGE_MAX:        vmax_q        <= cfg_data;
					bvm_pkg::REG_CHARGE_PIN_PRESENT: pin_present_q <= cfg_data[0];
					bvm_pkg::REG_CHARGE_ACTIVE_LOW:  active_low_q  <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.prep) begin
				if (stat_move) rep_stat_q <= pin_stat;
				if (volt_move) rep_volt_q <= v_q;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			adc_q <= adc_sample;
			ok_q  <= sample_ok;
			pin_q <= charge_pin;
		end
		if (cmd.scale) begin
			prod_q <= ProdW'(adc_q) * ProdW'(mult);
		end
		if (cmd.volt) begin
			v_q <= v_scaled;
		end
		if (cmd.prep) begin
			cap_zero_q <= (vmax_q <= vmin_q) || (v_q <= vmin_q);
			dead_q     <= !ok_q || (v_q < vmin_q);
			chg_q      <= stat_move || volt_move;
			vdiff_q    <= v_q - vmin_q;
			den_q      <= vmax_q - vmin_q;
		end
		if (cmd.num) begin
			num_q <= NumW'(vdiff_q) * NumW'(bvm_pkg::PctFull);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			if (rem_ge) begin
				rem_q <= VoltW'(rem_next - {1'b0, den_q});
			end else begin
				rem_q <= rem_next[VoltW-1:0];
			end
			num_q <= {num_q[NumW-2:0], rem_ge};
		end
		if (cmd.load_out) begin
			voltage_uv    <= ok_q ? v_q : '0;
			capacity_pct  <= (cap_zero_q || !ok_q) ? '0 : cap_val;
			health_dead   <= dead_q;
			charge_status <= rep_stat_q;
			read_error    <= !ok_q;
			changed       <= chg_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign stat.out_busy = out_valid_q && !out_ready;

endmodule
